// ----- rtl/core/msg_pkg.sv -----
// shared types, constants and helpers for the mean ssim block
// used by every module under rtl/core except msg_ram; depends on nothing
`default_nettype none

package msg_pkg;

    // default sizing, handed down from the top level
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT_DEF   = 256;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int WINDOW_SIZE_DEF  = 11;

    // field and register widths
    localparam int SAMPLE_W = 8;
    localparam int DIM_W    = 9;
    localparam int CH_W     = 3;
    localparam int POS_W    = 19;
    localparam int EXP_W    = 21;
    localparam int MEAN_W   = 18;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // arithmetic constants, q16.16
    localparam logic [34:0] C1_Q16 = 35'd426148;
    localparam logic [34:0] C2_Q16 = 35'd3835331;
    localparam int HALF16 = 32768;

    // shared divider sizing
    localparam int DIV_NW = 53;
    localparam int DIV_DW = 35;
    localparam int DIV_QW = 18;

    // one load handed from the front to the back
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CH_W-1:0]  channels;
        logic [EXP_W-1:0] expected;
        logic             bad;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ISSUE,
        B_DRAIN,
        B_MOMENT,
        B_SQUARE,
        B_RATIO,
        B_START1,
        B_DIV1,
        B_START2,
        B_DIV2,
        B_PROD,
        B_ACC,
        B_MEANSTART,
        B_MEANDIV,
        B_OUT
    } back_state_t;

    // gaussian taps, sigma 1.5, q0.16
    localparam logic [15:0] TAPS [11] = '{
        16'd67, 16'd498, 16'd2359, 16'd7166, 16'd13988, 16'd17380,
        16'd13988, 16'd7166, 16'd2359, 16'd498, 16'd67
    };

    // centred tap lookup, zero outside the table
    function automatic logic [15:0] tap_weight(input logic [3:0] k, input logic [3:0] off);
        logic signed [5:0] t;
        logic [15:0] w;
        t = $signed({2'b00, k}) - $signed({2'b00, off}) + 6'sd5;
        w = 16'd0;
        if (t >= 6'sd0 && t <= 6'sd10)
        begin
            w = TAPS[t[3:0]];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/msg_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module msg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/msg_front.sv -----
// load side: configuration registers, sample store writes, count check
// depends on msg_pkg
`default_nettype none

module msg_front #(
    parameter int MAX_WIDTH    = msg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = msg_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CHANNELS = msg_pkg::MAX_CHANNELS_DEF,
    parameter int DEPTH        = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 accept,
    input  wire logic [msg_pkg::SAMPLE_W-1:0]         sample_a,
    input  wire logic [msg_pkg::SAMPLE_W-1:0]         sample_b,
    input  wire logic                                 last_sample,
    input  wire logic                                 cfg_wen,
    input  wire logic [msg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [msg_pkg::DIM_W-1:0]            cfg_data,
    output logic                                      ram_we,
    output logic [AW-1:0]                             ram_waddr,
    output logic [2*msg_pkg::SAMPLE_W-1:0]            ram_wdata,
    output logic                                      push,
    output msg_pkg::job_t                             job
);

    localparam logic [msg_pkg::POS_W-1:0] POS_MAX = '1;

    logic [msg_pkg::DIM_W-1:0] width_reg;
    logic [msg_pkg::DIM_W-1:0] height_reg;
    logic [msg_pkg::CH_W-1:0]  channels_reg;
    logic [msg_pkg::POS_W-1:0] pos_reg;
    logic [msg_pkg::POS_W-1:0] pos_next;
    logic [msg_pkg::EXP_W-1:0] expected;
    logic                      regs_bad;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= msg_pkg::DIM_W'(1);
            height_reg   <= msg_pkg::DIM_W'(1);
            channels_reg <= msg_pkg::CH_W'(3);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                msg_pkg::REG_IMAGE_WIDTH:   width_reg    <= cfg_data;
                msg_pkg::REG_IMAGE_HEIGHT:  height_reg   <= cfg_data;
                msg_pkg::REG_CHANNEL_COUNT: channels_reg <= cfg_data[msg_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating pair count
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= last_sample ? '0 : pos_next;
        end
    end

    // store write, dropped beyond the store
    assign ram_we    = accept && (32'(pos_reg) < 32'(DEPTH));
    assign ram_waddr = AW'(pos_reg);
    assign ram_wdata = {sample_a, sample_b};

    // classify the load on its last word
    assign expected = msg_pkg::EXP_W'(msg_pkg::EXP_W'(width_reg) * msg_pkg::EXP_W'(height_reg))
                      * msg_pkg::EXP_W'(channels_reg);
    assign regs_bad = (width_reg == '0) || (32'(width_reg) > 32'(MAX_WIDTH))
                   || (height_reg == '0) || (32'(height_reg) > 32'(MAX_HEIGHT))
                   || (channels_reg == '0) || (32'(channels_reg) > 32'(MAX_CHANNELS));

    assign push           = accept && last_sample;
    assign job.width      = width_reg;
    assign job.height     = height_reg;
    assign job.channels   = channels_reg;
    assign job.expected   = expected;
    assign job.bad        = regs_bad || (msg_pkg::EXP_W'(pos_next) != expected);

endmodule

`default_nettype wire

// ----- rtl/core/msg_queue.sv -----
// two entry job queue between the load side and the compute side
// depends on msg_pkg
`default_nettype none

module msg_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire msg_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               empty,
    output msg_pkg::job_t      head
);

    msg_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/core/msg_div.sv -----
// restoring divider, one quotient bit per cycle, shared by the compute side
// depends on msg_pkg
`default_nettype none

module msg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [msg_pkg::DIV_NW-1:0]  num,
    input  wire logic [msg_pkg::DIV_DW-1:0]  den,
    output logic                             done,
    output logic [msg_pkg::DIV_QW-1:0]       quot
);

    localparam int NW = msg_pkg::DIV_NW;
    localparam int QW = msg_pkg::DIV_QW;
    localparam int CW = $clog2(QW);

    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QW-1:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(QW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // trial subtract of the shifted divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= NW'(den) << (QW - 1);
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/msg_back.sv -----
// compute side: window walk, tap pipeline, per-window ssim, final mean
// depends on msg_pkg and msg_div
`default_nettype none

module msg_back #(
    parameter int WINDOW_SIZE = msg_pkg::WINDOW_SIZE_DEF,
    parameter int DEPTH       = msg_pkg::MAX_WIDTH_DEF * msg_pkg::MAX_HEIGHT_DEF
                                * msg_pkg::MAX_CHANNELS_DEF,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_empty,
    input  wire msg_pkg::job_t                    q_head,
    output logic                                  q_pop,
    output logic [AW-1:0]                         ram_raddr,
    input  wire logic [2*msg_pkg::SAMPLE_W-1:0]   ram_rdata,
    output logic                                  active,
    output logic                                  done,
    output logic signed [msg_pkg::MEAN_W-1:0]     mean_ssim,
    output logic                                  status
);

    localparam int KW  = $clog2(WINDOW_SIZE);
    localparam int OFF = WINDOW_SIZE / 2;
    localparam int DW  = msg_pkg::DIM_W;

    msg_pkg::back_state_t state_reg, state_next;
    msg_pkg::job_t        job_reg;

    // window and tap counters
    logic [DW-1:0]           cx_reg, cy_reg;
    logic [msg_pkg::CH_W-1:0] cc_reg;
    logic [KW-1:0]           kx_reg, ky_reg;

    // tap pipeline
    logic          va_reg, la_reg, vb_reg, lb_reg, vc_reg, lc_reg;
    logic          vd_reg, ld_reg, ve_reg, le_reg;
    logic [DW-1:0] sy_a_reg, sx_a_reg;
    logic [31:0]   wt_a_reg, wt_b_reg, wt_c_reg, wt_d_reg;
    logic [17:0]   pix_b_reg;
    logic [20:0]   addr_c_reg;
    logic [39:0]   pa_e_reg, pb_e_reg;
    logic [7:0]    a_e_reg, b_e_reg;

    // window sums
    logic [39:0] s1_reg, s2_reg;
    logic [47:0] s11_reg, s22_reg, s12_reg;
    logic        acc_last_reg;

    // per-window finish
    logic [23:0] m1_reg, m2_reg;
    logic [31:0] e11_reg, e22_reg, e12_reg;
    logic [31:0] q11_reg, q22_reg, q12_reg;
    logic [34:0] num1_reg, den1_reg, bmag_reg, den2_reg;
    logic        neg_reg;
    logic [msg_pkg::DIV_QW-1:0] r1_reg, r2_reg, meanq_reg;
    logic [35:0] prod_reg;
    logic signed [39:0] sum_reg;

    // outputs
    logic                               done_reg;
    logic                               status_reg;
    logic signed [msg_pkg::MEAN_W-1:0]  mean_reg;

    // combinational helpers
    logic          issue_last, win_last;
    logic [11:0]   ys, xs;
    logic [DW-1:0] sy_n, sx_n;
    logic [39:0]   rnd1, rnd2;
    logic [47:0]   rnd11, rnd22, rnd12, sq11, sq22, sq12;
    logic signed [33:0] v1, v2, cv, v1c, v2c;
    logic signed [35:0] bval;
    logic [20:0]   mag;
    logic [39:0]   abs_sum;
    logic [msg_pkg::DIV_QW-1:0] meanc;
    logic          div_start, div_done;
    logic [msg_pkg::DIV_NW-1:0] div_num;
    logic [msg_pkg::DIV_DW-1:0] div_den;
    logic [msg_pkg::DIV_QW-1:0] div_quot;
    logic [7:0]    rd_a, rd_b;

    assign issue_last = (kx_reg == KW'(WINDOW_SIZE - 1)) && (ky_reg == KW'(WINDOW_SIZE - 1));
    assign win_last = (cc_reg == job_reg.channels - 1'b1) && (cx_reg == job_reg.width - 1'b1)
                   && (cy_reg == job_reg.height - 1'b1);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msg_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and divider control
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = msg_pkg::DIV_NW'(abs_sum) + msg_pkg::DIV_NW'(job_reg.expected >> 1);
        div_den    = msg_pkg::DIV_DW'(job_reg.expected);
        case (state_reg)
            msg_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_head.bad ? msg_pkg::B_OUT : msg_pkg::B_ISSUE;
                end
            end
            msg_pkg::B_ISSUE:  if (issue_last) state_next = msg_pkg::B_DRAIN;
            msg_pkg::B_DRAIN:  if (acc_last_reg) state_next = msg_pkg::B_MOMENT;
            msg_pkg::B_MOMENT: state_next = msg_pkg::B_SQUARE;
            msg_pkg::B_SQUARE: state_next = msg_pkg::B_RATIO;
            msg_pkg::B_RATIO:  state_next = msg_pkg::B_START1;
            msg_pkg::B_START1:
            begin
                div_start  = 1'b1;
                div_num    = (msg_pkg::DIV_NW'(num1_reg) << 16) + msg_pkg::DIV_NW'(den1_reg >> 1);
                div_den    = den1_reg;
                state_next = msg_pkg::B_DIV1;
            end
            msg_pkg::B_DIV1:   if (div_done) state_next = msg_pkg::B_START2;
            msg_pkg::B_START2:
            begin
                div_start  = 1'b1;
                div_num    = (msg_pkg::DIV_NW'(bmag_reg) << 16) + msg_pkg::DIV_NW'(den2_reg >> 1);
                div_den    = den2_reg;
                state_next = msg_pkg::B_DIV2;
            end
            msg_pkg::B_DIV2:   if (div_done) state_next = msg_pkg::B_PROD;
            msg_pkg::B_PROD:   state_next = msg_pkg::B_ACC;
            msg_pkg::B_ACC:    state_next = win_last ? msg_pkg::B_MEANSTART : msg_pkg::B_ISSUE;
            msg_pkg::B_MEANSTART:
            begin
                div_start  = 1'b1;
                state_next = msg_pkg::B_MEANDIV;
            end
            msg_pkg::B_MEANDIV: if (div_done) state_next = msg_pkg::B_OUT;
            msg_pkg::B_OUT:    state_next = msg_pkg::B_IDLE;
            default:           state_next = msg_pkg::B_IDLE;
        endcase
    end

    // edge-replicated source coordinates of the issued tap
    always_comb
    begin
        ys = 12'(cy_reg) + 12'(ky_reg) - 12'(OFF);
        xs = 12'(cx_reg) + 12'(kx_reg) - 12'(OFF);
        if (ys[11])
            sy_n = '0;
        else if (ys >= 12'(job_reg.height))
            sy_n = job_reg.height - 1'b1;
        else
            sy_n = ys[DW-1:0];
        if (xs[11])
            sx_n = '0;
        else if (xs >= 12'(job_reg.width))
            sx_n = job_reg.width - 1'b1;
        else
            sx_n = xs[DW-1:0];
    end

    assign rd_a = ram_rdata[15:8];
    assign rd_b = ram_rdata[7:0];
    assign ram_raddr = AW'(addr_c_reg);

    // tap pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0; vb_reg <= 1'b0; vc_reg <= 1'b0;
            vd_reg <= 1'b0; ve_reg <= 1'b0; acc_last_reg <= 1'b0;
        end
        else
        begin
            va_reg       <= (state_reg == msg_pkg::B_ISSUE);
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            vd_reg       <= vc_reg;
            ve_reg       <= vd_reg;
            acc_last_reg <= ve_reg && le_reg;
        end
    end

    // tap pipeline data
    always_ff @(posedge clk)
    begin
        la_reg     <= issue_last;
        sy_a_reg   <= sy_n;
        sx_a_reg   <= sx_n;
        wt_a_reg   <= 32'(msg_pkg::tap_weight(4'(ky_reg), 4'(OFF)))
                      * 32'(msg_pkg::tap_weight(4'(kx_reg), 4'(OFF)));
        lb_reg     <= la_reg;
        pix_b_reg  <= 18'(sy_a_reg) * 18'(job_reg.width) + 18'(sx_a_reg);
        wt_b_reg   <= wt_a_reg;
        lc_reg     <= lb_reg;
        addr_c_reg <= 21'(pix_b_reg) * 21'(job_reg.channels) + 21'(cc_reg);
        wt_c_reg   <= wt_b_reg;
        ld_reg     <= lc_reg;
        wt_d_reg   <= wt_c_reg;
        le_reg     <= ld_reg;
        pa_e_reg   <= 40'(wt_d_reg) * 40'(rd_a);
        pb_e_reg   <= 40'(wt_d_reg) * 40'(rd_b);
        a_e_reg    <= rd_a;
        b_e_reg    <= rd_b;
    end

    // rounding of moments and mean products
    assign rnd1  = s1_reg + 40'(msg_pkg::HALF16);
    assign rnd2  = s2_reg + 40'(msg_pkg::HALF16);
    assign rnd11 = s11_reg + 48'(msg_pkg::HALF16);
    assign rnd22 = s22_reg + 48'(msg_pkg::HALF16);
    assign rnd12 = s12_reg + 48'(msg_pkg::HALF16);
    assign sq11  = 48'(m1_reg) * 48'(m1_reg) + 48'(msg_pkg::HALF16);
    assign sq22  = 48'(m2_reg) * 48'(m2_reg) + 48'(msg_pkg::HALF16);
    assign sq12  = 48'(m1_reg) * 48'(m2_reg) + 48'(msg_pkg::HALF16);

    // variances, covariance and ratio terms
    always_comb
    begin
        v1   = $signed(34'(e11_reg)) - $signed(34'(q11_reg));
        v2   = $signed(34'(e22_reg)) - $signed(34'(q22_reg));
        cv   = $signed(34'(e12_reg)) - $signed(34'(q12_reg));
        v1c  = v1[33] ? '0 : v1;
        v2c  = v2[33] ? '0 : v2;
        bval = ($signed(36'(cv)) <<< 1) + $signed(36'(msg_pkg::C2_Q16));
    end

    assign mag     = 21'((prod_reg + 36'(msg_pkg::HALF16)) >> 16);
    assign abs_sum = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);
    assign meanc   = (meanq_reg > msg_pkg::DIV_QW'(65536)) ? msg_pkg::DIV_QW'(65536) : meanq_reg;

    // sequencer counters and per-window arithmetic
    always_ff @(posedge clk)
    begin
        case (state_reg)
            msg_pkg::B_IDLE:
            begin
                job_reg <= q_head;
                cx_reg  <= '0;
                cy_reg  <= '0;
                cc_reg  <= '0;
                kx_reg  <= '0;
                ky_reg  <= '0;
                sum_reg <= '0;
            end
            msg_pkg::B_ISSUE:
            begin
                if (kx_reg == KW'(WINDOW_SIZE - 1))
                begin
                    kx_reg <= '0;
                    ky_reg <= issue_last ? '0 : ky_reg + 1'b1;
                end
                else
                begin
                    kx_reg <= kx_reg + 1'b1;
                end
            end
            msg_pkg::B_MOMENT:
            begin
                m1_reg  <= rnd1[39:16];
                m2_reg  <= rnd2[39:16];
                e11_reg <= rnd11[47:16];
                e22_reg <= rnd22[47:16];
                e12_reg <= rnd12[47:16];
            end
            msg_pkg::B_SQUARE:
            begin
                q11_reg <= sq11[47:16];
                q22_reg <= sq22[47:16];
                q12_reg <= sq12[47:16];
            end
            msg_pkg::B_RATIO:
            begin
                num1_reg <= {q12_reg, 1'b0} + msg_pkg::C1_Q16;
                den1_reg <= 35'(q11_reg) + 35'(q22_reg) + msg_pkg::C1_Q16;
                neg_reg  <= bval[35];
                bmag_reg <= bval[35] ? 35'(-bval) : 35'(bval);
                den2_reg <= 35'(v1c) + 35'(v2c) + msg_pkg::C2_Q16;
            end
            msg_pkg::B_DIV1:    if (div_done) r1_reg <= div_quot;
            msg_pkg::B_DIV2:    if (div_done) r2_reg <= div_quot;
            msg_pkg::B_PROD:    prod_reg <= 36'(r1_reg) * 36'(r2_reg);
            msg_pkg::B_ACC:
            begin
                sum_reg <= neg_reg ? sum_reg - $signed(40'(mag)) : sum_reg + $signed(40'(mag));
                if (cc_reg == job_reg.channels - 1'b1)
                begin
                    cc_reg <= '0;
                    if (cx_reg == job_reg.width - 1'b1)
                    begin
                        cx_reg <= '0;
                        cy_reg <= cy_reg + 1'b1;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + 1'b1;
                    end
                end
                else
                begin
                    cc_reg <= cc_reg + 1'b1;
                end
            end
            msg_pkg::B_MEANDIV: if (div_done) meanq_reg <= div_quot;
            default: ;
        endcase
    end

    // window sums, cleared as a window starts
    always_ff @(posedge clk)
    begin
        if (state_next == msg_pkg::B_ISSUE && state_reg != msg_pkg::B_ISSUE)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s11_reg <= '0;
            s22_reg <= '0;
            s12_reg <= '0;
        end
        else if (ve_reg)
        begin
            s1_reg  <= s1_reg + pa_e_reg;
            s2_reg  <= s2_reg + pb_e_reg;
            s11_reg <= s11_reg + 48'(pa_e_reg) * 48'(a_e_reg);
            s22_reg <= s22_reg + 48'(pb_e_reg) * 48'(b_e_reg);
            s12_reg <= s12_reg + 48'(pa_e_reg) * 48'(b_e_reg);
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == msg_pkg::B_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == msg_pkg::B_OUT)
        begin
            status_reg <= job_reg.bad;
            if (job_reg.bad)
                mean_reg <= '0;
            else if (sum_reg[39])
                mean_reg <= -$signed(msg_pkg::MEAN_W'(meanc));
            else
                mean_reg <= $signed(msg_pkg::MEAN_W'(meanc));
        end
    end

    msg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign active    = (state_reg != msg_pkg::B_IDLE);
    assign done      = done_reg;
    assign mean_ssim = mean_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mean_ssim_gaussian_window.sv -----
// top level of the mean ssim block: load side, job queue, compute side, store
// depends on msg_pkg, msg_ram, msg_front, msg_queue, msg_back
`default_nettype none

// Sample pairs are taken one per cycle while busy is low (start high), in raster
// order, and written to a single sample store. The word flagged last_sample starts
// the computation and busy stays high until the result is out. There is one window
// per pixel and channel, width*height*channels in all. Each window issues its store
// reads, one per tap, through the one read port, drains the read pipeline, rounds
// the moments, squares the means and forms the ratio terms, runs two divisions
// (start, 18 quotient bits, hand-over) and then forms the product and the running
// sum. The mean over the image takes one more division after the last window.
// A bad sample count or an invalid register skips the windows and gives status 1.
// The result is shown on mean_ssim and status for exactly one cycle with done high
// and cannot be held off, so the receiver must take it then. The store needs no
// clearing after reset.
module mean_ssim_gaussian_window #(
    parameter int MAX_WIDTH    = msg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = msg_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CHANNELS = msg_pkg::MAX_CHANNELS_DEF,
    parameter int WINDOW_SIZE  = msg_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [msg_pkg::SAMPLE_W-1:0]         sample_a,
    input  wire logic [msg_pkg::SAMPLE_W-1:0]         sample_b,
    input  wire logic                                 last_sample,
    input  wire logic                                 cfg_wen,
    input  wire logic [msg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [msg_pkg::DIM_W-1:0]            cfg_data,
    output logic                                      done,
    output logic signed [msg_pkg::MEAN_W-1:0]         mean_ssim,
    output logic                                      status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                              accept;
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [2*msg_pkg::SAMPLE_W-1:0]    ram_wdata, ram_rdata;
    logic                              push, pop, q_empty, back_active;
    msg_pkg::job_t                     push_job, q_head;

    // handshake
    assign accept = start && !busy;
    assign busy   = !q_empty || back_active;

    msg_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .DEPTH        (DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .last_sample (last_sample),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .push        (push),
        .job         (push_job)
    );

    msg_ram #(
        .WIDTH (2 * msg_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    msg_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .DEPTH       (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .active    (back_active),
        .done      (done),
        .mean_ssim (mean_ssim),
        .status    (status)
    );

endmodule

`default_nettype wire
